// ===== src/lbpg_pkg.sv =====
`default_nettype none
package lbpg_pkg;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned STEP_W  = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // Command codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_OFF    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SOLID  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_BLINK  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DOUBLE = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_FAIL   = 3'd5;

    // Mode codes as reported on the result port.
    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SOLID  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLINK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FAIL   = 3'd4;

    // Double-blink step codes.
    localparam logic [STEP_W-1:0] STEP_PULSE_A = 2'd0;
    localparam logic [STEP_W-1:0] STEP_GAP     = 2'd1;
    localparam logic [STEP_W-1:0] STEP_PULSE_B = 2'd2;
    localparam logic [STEP_W-1:0] STEP_REST    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_HALF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_MIN = 2'd3;

    localparam logic [TICK_W-1:0] RST_FAIL_HALF  = 16'd150;
    localparam logic [TICK_W-1:0] RST_PULSE      = 16'd100;
    localparam logic [TICK_W-1:0] RST_GAP        = 16'd100;
    localparam logic [TICK_W-1:0] RST_DOUBLE_MIN = 16'd400;

    typedef struct packed {
        logic [TICK_W-1:0] fail_half_ticks;
        logic [TICK_W-1:0] pulse_ticks;
        logic [TICK_W-1:0] gap_ticks;
        logic [TICK_W-1:0] double_min_period;
    } t_cfg;

    typedef struct packed {
        logic              blue_on;
        logic [MODE_W-1:0] mode_now;
    } t_result;

    // A wait that works out to zero ticks is loaded as one tick.
    function automatic logic [TICK_W-1:0] wait_of(input logic [TICK_W-1:0] t);
        logic [TICK_W-1:0] w;
        w = (t == '0) ? TICK_W'(1) : t;
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== src/led_blink_pattern_generator_unit.sv =====
// The input register captures a word when it is taken, and the state and result registers
// update together when the held word advances. Throughput: one word per cycle unless the
// receiver stalls; the input and result registers decouple the two sides.
// Reset (synchronous, active low) turns the engine's LED state off, selects off mode, clears all
// counters and loads the configuration registers with their default values.
`default_nettype none
module led_blink_pattern_generator_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [lbpg_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [lbpg_pkg::TICK_W-1:0]    i_period_ms,
    input  wire logic [lbpg_pkg::COUNT_W-1:0]   i_pulse_count,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_blue_on,
    output logic [lbpg_pkg::MODE_W-1:0]         o_mode_now,
    input  wire logic                           i_cfg_we,
    input  wire logic [lbpg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lbpg_pkg::TICK_W-1:0]    i_cfg_data
);

    lbpg_pkg::t_cfg              r_cfg;
    logic                        r_in_valid;
    logic [lbpg_pkg::FUNC_W-1:0]  r_func;
    logic [lbpg_pkg::TICK_W-1:0]  r_period;
    logic [lbpg_pkg::COUNT_W-1:0] r_count;
    logic                        r_out_valid;
    lbpg_pkg::t_result           r_out;
    lbpg_pkg::t_result           next_res;
    logic                        advance;
    logic                        take_in;

    // The held word moves into the state update when the result register is free.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign take_in = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fail_half_ticks   <= lbpg_pkg::RST_FAIL_HALF;
            r_cfg.pulse_ticks       <= lbpg_pkg::RST_PULSE;
            r_cfg.gap_ticks         <= lbpg_pkg::RST_GAP;
            r_cfg.double_min_period <= lbpg_pkg::RST_DOUBLE_MIN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lbpg_pkg::CFG_FAIL_HALF:  r_cfg.fail_half_ticks   <= i_cfg_data;
                lbpg_pkg::CFG_PULSE:      r_cfg.pulse_ticks       <= i_cfg_data;
                lbpg_pkg::CFG_GAP:        r_cfg.gap_ticks         <= i_cfg_data;
                lbpg_pkg::CFG_DOUBLE_MIN: r_cfg.double_min_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_func   <= i_func;
            r_period <= i_period_ms;
            r_count  <= i_pulse_count;
        end
    end

    lbpg_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_func        (r_func),
        .i_period_ms   (r_period),
        .i_pulse_count (r_count),
        .i_cfg         (r_cfg),
        .o_next        (next_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= next_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_blue_on  = r_out.blue_on;
    assign o_mode_now = r_out.mode_now;

endmodule
`default_nettype wire

// ===== src/lbpg_engine.sv =====
`default_nettype none
module lbpg_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic [lbpg_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [lbpg_pkg::TICK_W-1:0]   i_period_ms,
    input  wire logic [lbpg_pkg::COUNT_W-1:0]  i_pulse_count,
    input  wire lbpg_pkg::t_cfg                i_cfg,
    output lbpg_pkg::t_result                  o_next
);

    logic [lbpg_pkg::MODE_W-1:0]  r_mode, n_mode;
    logic                         r_led, n_led;
    logic [lbpg_pkg::TICK_W-1:0]  r_wait, n_wait;
    logic [lbpg_pkg::TICK_W-1:0]  r_period, n_period;
    logic [lbpg_pkg::STEP_W-1:0]  r_step, n_step;
    logic [lbpg_pkg::COUNT_W-1:0] r_toggles, n_toggles;

    // Rest of a double-blink cycle, computed wide and signed so that it cannot wrap.
    logic signed [lbpg_pkg::TICK_W+2:0] rest_wide;
    logic [lbpg_pkg::TICK_W-1:0]        rest_ticks;
    logic                               dbl_short;

    assign rest_wide = $signed({3'b000, r_period})
                     - $signed({2'b00, i_cfg.pulse_ticks, 1'b0})
                     - $signed({3'b000, i_cfg.gap_ticks});
    assign rest_ticks = (rest_wide < 19'sd1) ? lbpg_pkg::TICK_W'(1)
                                             : rest_wide[lbpg_pkg::TICK_W-1:0];
    assign dbl_short = (i_period_ms < i_cfg.double_min_period);

    always_comb begin
        n_mode    = r_mode;
        n_led     = r_led;
        n_wait    = r_wait;
        n_period  = r_period;
        n_step    = r_step;
        n_toggles = r_toggles;

        case (i_func)
            lbpg_pkg::FUNC_TICK: begin
                if (r_mode inside {lbpg_pkg::MODE_BLINK, lbpg_pkg::MODE_DOUBLE,
                                   lbpg_pkg::MODE_FAIL}) begin
                    if (r_wait > lbpg_pkg::TICK_W'(1)) begin
                        n_wait = r_wait - lbpg_pkg::TICK_W'(1);
                    end else begin
                        case (r_mode)
                            lbpg_pkg::MODE_BLINK: begin
                                n_led  = ~r_led;
                                n_wait = lbpg_pkg::wait_of(r_period >> 1);
                            end
                            lbpg_pkg::MODE_DOUBLE: begin
                                n_step = r_step + lbpg_pkg::STEP_W'(1);
                                case (r_step)
                                    lbpg_pkg::STEP_PULSE_A, lbpg_pkg::STEP_PULSE_B: begin
                                        n_led  = 1'b1;
                                        n_wait = lbpg_pkg::wait_of(i_cfg.pulse_ticks);
                                    end
                                    lbpg_pkg::STEP_GAP: begin
                                        n_led  = 1'b0;
                                        n_wait = lbpg_pkg::wait_of(i_cfg.gap_ticks);
                                    end
                                    default: begin
                                        n_led  = 1'b0;
                                        n_wait = rest_ticks;
                                    end
                                endcase
                            end
                            default: begin
                                if (r_toggles == '0) begin
                                    n_mode = lbpg_pkg::MODE_OFF;
                                    n_led  = 1'b0;
                                    n_step = '0;
                                    n_wait = '0;
                                end else begin
                                    n_led     = ~r_led;
                                    n_toggles = r_toggles - lbpg_pkg::COUNT_W'(1);
                                    n_wait    = lbpg_pkg::wait_of(i_cfg.fail_half_ticks);
                                end
                            end
                        endcase
                    end
                end
            end
            lbpg_pkg::FUNC_SOLID: begin
                n_mode    = lbpg_pkg::MODE_SOLID;
                n_led     = 1'b1;
                n_step    = '0;
                n_toggles = '0;
                n_wait    = '0;
            end
            lbpg_pkg::FUNC_BLINK, lbpg_pkg::FUNC_DOUBLE: begin
                n_step    = '0;
                n_toggles = '0;
                if (i_period_ms == '0) begin
                    n_mode = lbpg_pkg::MODE_OFF;
                    n_led  = 1'b0;
                    n_wait = '0;
                end else if (i_func == lbpg_pkg::FUNC_BLINK || dbl_short) begin
                    n_mode   = lbpg_pkg::MODE_BLINK;
                    n_period = i_period_ms;
                    n_led    = 1'b1;
                    n_wait   = lbpg_pkg::wait_of(i_period_ms >> 1);
                end else begin
                    n_mode   = lbpg_pkg::MODE_DOUBLE;
                    n_period = i_period_ms;
                    n_step   = lbpg_pkg::STEP_GAP;
                    n_led    = 1'b1;
                    n_wait   = lbpg_pkg::wait_of(i_cfg.pulse_ticks);
                end
            end
            lbpg_pkg::FUNC_FAIL: begin
                n_step = '0;
                if (i_pulse_count == '0) begin
                    n_mode    = lbpg_pkg::MODE_OFF;
                    n_led     = 1'b0;
                    n_toggles = '0;
                    n_wait    = '0;
                end else begin
                    n_mode    = lbpg_pkg::MODE_FAIL;
                    // Twice the count less one, kept to eight bits.
                    n_toggles = {i_pulse_count[lbpg_pkg::COUNT_W-2:0], 1'b0}
                              - lbpg_pkg::COUNT_W'(1);
                    n_led     = 1'b1;
                    n_wait    = lbpg_pkg::wait_of(i_cfg.fail_half_ticks);
                end
            end
            lbpg_pkg::FUNC_OFF: begin
                n_mode    = lbpg_pkg::MODE_OFF;
                n_led     = 1'b0;
                n_step    = '0;
                n_toggles = '0;
                n_wait    = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= lbpg_pkg::MODE_OFF;
            r_led     <= 1'b0;
            r_wait    <= '0;
            r_period  <= '0;
            r_step    <= '0;
            r_toggles <= '0;
        end else if (i_en) begin
            r_mode    <= n_mode;
            r_led     <= n_led;
            r_wait    <= n_wait;
            r_period  <= n_period;
            r_step    <= n_step;
            r_toggles <= n_toggles;
        end
    end

    assign o_next.blue_on  = n_led;
    assign o_next.mode_now = n_mode;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import lbpg_pkg::*;

    // The two func codes that the block leaves undefined.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

    localparam int unsigned PHASE_WORDS   = 155;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned HOLD_AT       = 700;
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned MAX_PRINTED   = 100;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [TICK_W-1:0]  period;
        logic [COUNT_W-1:0] count;
    } t_led_cmd;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [TICK_W-1:0]    i_period_ms = '0;
    logic [COUNT_W-1:0]   i_pulse_count = '0;
    logic                 i_stall = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TICK_W-1:0]    i_cfg_data = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic                 o_blue_on;
    logic [MODE_W-1:0]    o_mode_now;

    led_blink_pattern_generator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_period_ms   (i_period_ms),
        .i_pulse_count (i_pulse_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_blue_on     (o_blue_on),
        .o_mode_now    (o_mode_now),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Predicted LED state and the configuration it runs under.
    t_cfg              cfg_now = '{RST_FAIL_HALF, RST_PULSE, RST_GAP, RST_DOUBLE_MIN};
    logic [MODE_W-1:0]  pm_mode = MODE_OFF;
    logic               pm_led = 1'b0;
    logic [TICK_W-1:0]  pm_wait = '0;
    logic [TICK_W-1:0]  pm_period = '0;
    logic [STEP_W-1:0]  pm_step = STEP_PULSE_A;
    logic [COUNT_W-1:0] pm_toggles = '0;

    t_led_cmd    cmd_q[$];
    t_result     led_expected_q[$];
    t_led_cmd    word_out;
    t_result     want_word;
    int unsigned send_idle_pct = 26;
    int unsigned recv_stall_pct = 59;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    function automatic void arm_wait(input logic [TICK_W-1:0] t);
        pm_wait = (t == '0) ? TICK_W'(1) : t;
    endfunction

    function automatic void clear_pattern();
        pm_led = 1'b0;
        pm_step = STEP_PULSE_A;
        pm_toggles = '0;
        pm_wait = '0;
    endfunction

    function automatic void go_dark();
        clear_pattern();
        pm_mode = MODE_OFF;
    endfunction

    function automatic void begin_blink(input logic [TICK_W-1:0] p);
        if (p == '0) begin
            go_dark();
        end else begin
            clear_pattern();
            pm_mode = MODE_BLINK;
            pm_period = p;
            pm_led = 1'b1;
            arm_wait(p >> 1);
        end
    endfunction

    function automatic t_result step_led(input t_led_cmd c);
        t_result           r;
        int                rest;
        logic [TICK_W-1:0] nxt;
        case (c.func)
            FUNC_TICK: begin
                if (pm_mode == MODE_BLINK || pm_mode == MODE_DOUBLE || pm_mode == MODE_FAIL) begin
                    if (pm_wait > TICK_W'(1)) begin
                        pm_wait = pm_wait - TICK_W'(1);
                    end else begin
                        pm_wait = '0;
                        if (pm_mode == MODE_BLINK) begin
                            pm_led = ~pm_led;
                            arm_wait(pm_period >> 1);
                        end else if (pm_mode == MODE_DOUBLE) begin
                            if (pm_step == STEP_GAP) begin
                                pm_led = 1'b0;
                                nxt = cfg_now.gap_ticks;
                            end else if (pm_step == STEP_REST) begin
                                // The rest may come out negative; it never drops below one tick.
                                rest = int'(pm_period) - 2 * int'(cfg_now.pulse_ticks)
                                       - int'(cfg_now.gap_ticks);
                                pm_led = 1'b0;
                                nxt = (rest < 1) ? TICK_W'(1) : TICK_W'(rest);
                            end else begin
                                pm_led = 1'b1;
                                nxt = cfg_now.pulse_ticks;
                            end
                            pm_step = pm_step + STEP_W'(1);
                            arm_wait(nxt);
                        end else if (pm_toggles == '0) begin
                            go_dark();
                        end else begin
                            pm_led = ~pm_led;
                            pm_toggles = pm_toggles - COUNT_W'(1);
                            arm_wait(cfg_now.fail_half_ticks);
                        end
                    end
                end
            end
            FUNC_OFF: go_dark();
            FUNC_SOLID: begin
                clear_pattern();
                pm_mode = MODE_SOLID;
                pm_led = 1'b1;
            end
            FUNC_BLINK: begin_blink(c.period);
            FUNC_DOUBLE: begin
                if (c.period == '0) begin
                    go_dark();
                end else if (c.period < cfg_now.double_min_period) begin
                    begin_blink(c.period);
                end else begin
                    clear_pattern();
                    pm_mode = MODE_DOUBLE;
                    pm_period = c.period;
                    pm_step = STEP_GAP;
                    pm_led = 1'b1;
                    arm_wait(cfg_now.pulse_ticks);
                end
            end
            FUNC_FAIL: begin
                if (c.count == '0) begin
                    go_dark();
                end else begin
                    clear_pattern();
                    pm_mode = MODE_FAIL;
                    // Twice the count less one, wrapped to eight bits.
                    pm_toggles = {c.count[COUNT_W-2:0], 1'b0} - COUNT_W'(1);
                    pm_led = 1'b1;
                    arm_wait(cfg_now.fail_half_ticks);
                end
            end
            default: ;
        endcase
        r.blue_on = pm_led;
        r.mode_now = pm_mode;
        return r;
    endfunction

    function automatic t_led_cmd random_cmd();
        t_led_cmd    c;
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(99);
        span = cfg_now.double_min_period + 2 * cfg_now.pulse_ticks + cfg_now.gap_ticks + 10;
        if (span > 65535) begin
            span = 65535;
        end
        c.func = FUNC_TICK;
        c.period = TICK_W'($urandom);
        c.count = COUNT_W'($urandom);
        if (roll < 60) begin
            c.func = FUNC_TICK;
        end else if (roll < 64) begin
            c.func = FUNC_OFF;
        end else if (roll < 67) begin
            c.func = FUNC_SOLID;
        end else if (roll < 77) begin
            c.func = FUNC_BLINK;
            c.period = TICK_W'($urandom_range(0, 24));
        end else if (roll < 87) begin
            c.func = FUNC_DOUBLE;
            c.period = TICK_W'($urandom_range(0, span));
        end else if (roll < 94) begin
            c.func = FUNC_FAIL;
            c.count = COUNT_W'($urandom_range(0, 5));
        end else if (roll < 97) begin
            c.func = FUNC_W'($urandom);
        end else begin
            c.func = FUNC_W'($urandom_range(FUNC_BLINK, FUNC_FAIL));
        end
        return c;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    // Sender: predicts each word as it is taken and offers the next one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                led_expected_q.push_back(step_led(t_led_cmd'({i_func, i_period_ms, i_pulse_count})));
            end
            if (!i_valid || !o_stall) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    word_out = cmd_q.pop_front();
                    i_valid <= 1'b1;
                    i_func <= word_out.func;
                    i_period_ms <= word_out.period;
                    i_pulse_count <= word_out.count;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so that the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            i_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (led_expected_q.size() == 0) begin
                flag_mismatch($sformatf("result word with nothing expected: blue_on %0b mode %0d",
                                        o_blue_on, o_mode_now));
            end else begin
                want_word = led_expected_q.pop_front();
                if (o_blue_on !== want_word.blue_on) begin
                    flag_mismatch($sformatf("word %0d blue_on got %0b want %0b",
                                            results_seen, o_blue_on, want_word.blue_on));
                end
                if (o_mode_now !== want_word.mode_now) begin
                    flag_mismatch($sformatf("word %0d mode_now got %0d want %0d",
                                            results_seen, o_mode_now, want_word.mode_now));
                end
            end
            results_seen <= results_seen + 1;
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic add_cmd(input logic [FUNC_W-1:0] f, input logic [TICK_W-1:0] p,
                           input logic [COUNT_W-1:0] c);
        cmd_q.push_back('{f, p, c});
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
    endtask

    task automatic apply_setting(input logic [TICK_W-1:0] f, input logic [TICK_W-1:0] p,
                                 input logic [TICK_W-1:0] g, input logic [TICK_W-1:0] d);
        put_reg(CFG_FAIL_HALF, f);
        put_reg(CFG_PULSE, p);
        put_reg(CFG_GAP, g);
        put_reg(CFG_DOUBLE_MIN, d);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_now = '{f, p, g, d};
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (cmd_q.size() != 0 || i_valid || led_expected_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int ph;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_cmd(FUNC_TICK, '0, '0);
        add_cmd(FUNC_SOLID, '0, '0);
        add_cmd(FUNC_TICK, '1, '1);
        add_cmd(FUNC_SPARE_A, '1, '1);
        add_cmd(FUNC_BLINK, '0, '1);
        add_cmd(FUNC_DOUBLE, '0, '1);
        add_cmd(FUNC_FAIL, '1, '0);
        // A blink of period one has a zero half period, taken as one tick.
        add_cmd(FUNC_BLINK, TICK_W'(1), '0);
        add_cmd(FUNC_TICK, '0, '0);
        add_cmd(FUNC_TICK, '0, '0);
        add_cmd(FUNC_BLINK, '1, '0);
        add_cmd(FUNC_TICK, '0, '0);
        add_cmd(FUNC_DOUBLE, RST_DOUBLE_MIN - TICK_W'(1), '0);
        add_cmd(FUNC_DOUBLE, RST_DOUBLE_MIN, '0);
        add_cmd(FUNC_DOUBLE, '1, '1);
        add_cmd(FUNC_TICK, '1, '0);
        add_cmd(FUNC_SPARE_B, '0, '0);
        add_cmd(FUNC_FAIL, '0, COUNT_W'(1));
        add_cmd(FUNC_TICK, '0, '0);
        add_cmd(FUNC_FAIL, '0, '1);
        add_cmd(FUNC_FAIL, '1, COUNT_W'(128));
        add_cmd(FUNC_OFF, '1, '1);
        add_cmd(FUNC_SOLID, '1, '1);
        add_cmd(FUNC_BLINK, TICK_W'(2), '0);
        add_cmd(FUNC_TICK, '0, '0);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: apply_setting(TICK_W'(1), TICK_W'(1), TICK_W'(1), TICK_W'(0));
                1: apply_setting(TICK_W'(3), TICK_W'(2), TICK_W'(4), TICK_W'(15));
                2: apply_setting('1, '1, '1, '1);
                3: apply_setting(TICK_W'(0), TICK_W'(0), TICK_W'(0), TICK_W'(6));
                4: apply_setting(TICK_W'($urandom_range(1, 6)), TICK_W'($urandom_range(1, 5)),
                                 TICK_W'($urandom_range(1, 5)), TICK_W'($urandom_range(0, 30)));
                default: apply_setting(TICK_W'(2), TICK_W'(3), TICK_W'(1), TICK_W'(20));
            endcase
            if (ph < 2) begin
                send_idle_pct = 26;
                recv_stall_pct = 59;
            end else if (ph < 4) begin
                send_idle_pct = 59;
                recv_stall_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            repeat (PHASE_WORDS) cmd_q.push_back(random_cmd());
            drain();
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
